// ----- src/gga_sentence_position_parser_top_defines.svh -----
// Assertion macros shared by the GGA position parser RTL
`ifndef GGA_SENTENCE_POSITION_PARSER_TOP_DEFINES_SVH
`define GGA_SENTENCE_POSITION_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define GSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/gsp_pkg.sv -----
// Shared constants, types and helper functions of the GGA position parser
package gsp_pkg;

  // Fraction digits kept for coordinates (1..5) and for the altitude
  localparam int         FRAC_DIGITS    = 5;
  localparam logic [2:0] FRAC_LIMIT     = 3'(FRAC_DIGITS);
  localparam logic [2:0] ALT_FRAC_LIMIT = 3'd3;

  localparam logic [3:0]  FIELDS_NEEDED = 4'd15;
  localparam logic [2:0]  PREFIX_LEN    = 3'd6;
  localparam logic [16:0] INT_SAT       = 17'd99999;
  localparam logic [33:0] COORD_MAX     = 34'd9999999999;

  // Reciprocal constants: x/100 for x < 100000, and 5*y/3 for y < 10^7
  localparam logic [17:0] RECIP100      = 18'd167773;   // ceil(2^24 / 100)
  localparam int          RECIP100_SH   = 24;
  localparam logic [26:0] FIVE_THIRDS   = 27'd111848107; // ceil(2^26 * 5 / 3)
  localparam int          FIVE_THIRDS_SH = 26;

  // Characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  // Field indexes that carry data
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_LAT_DIR = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_LON_DIR = 4'd5;
  localparam logic [3:0] FLD_ALT     = 4'd9;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_GGA = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  // Pipeline token kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_LAT  = 3'd1;
  localparam logic [2:0] KIND_LON  = 3'd2;
  localparam logic [2:0] KIND_ALT  = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  // Control part of a token, travels through every stage
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] status;
    logic       alt_neg;
    logic       neg_lat;
    logic       neg_lon;
  } gsp_tag_t;

  // Parser output: a finished field or the end of a sentence
  typedef struct packed {
    gsp_tag_t    tag;
    logic [16:0] int_acc;
    logic [16:0] frac_acc;
    logic [2:0]  frac_cnt;
  } gsp_event_t;

  // Converter output
  typedef struct packed {
    gsp_tag_t           tag;
    logic [33:0]        coord_mag;
    logic signed [27:0] alt;
  } gsp_result_t;

  // Expected sentence prefix "$GPGGA"
  function automatic logic [7:0] gsp_prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Powers of ten up to 10^5
  function automatic logic [16:0] gsp_pow10(input logic [2:0] e);
    logic [16:0] p;
    case (e)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage

// ----- src/gsp_parser.sv -----
// Byte-level sentence parser: prefix check, field split, number accumulation
module gsp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte_req,
  input  logic                in_last,
  input  logic                advance,
  output gsp_pkg::gsp_event_t ev_o
);

  logic [2:0]  prefix_pos_r,  prefix_pos_nxt;
  logic        prefix_fail_r, prefix_fail_nxt;
  logic [3:0]  field_idx_r,   field_idx_nxt;
  logic        last_comma_r,  last_comma_nxt;
  logic [1:0]  field_len_r,   field_len_nxt;
  logic [7:0]  first_char_r,  first_char_nxt;
  logic [16:0] int_acc_r,     int_acc_nxt;
  logic [16:0] frac_acc_r,    frac_acc_nxt;
  logic [2:0]  frac_cnt_r,    frac_cnt_nxt;
  logic        seen_point_r,  seen_point_nxt;
  logic        stopped_r,     stopped_nxt;
  logic        alt_neg_r,     alt_neg_nxt;
  logic        neg_lat_r,     neg_lat_nxt;
  logic        neg_lon_r,     neg_lon_nxt;
  gsp_pkg::gsp_event_t ev_r, ev_nxt;

  logic accept;

  assign in_stall = ~advance;
  assign accept   = in_valid & advance;
  assign ev_o     = ev_r;

  // Next parser state for the byte on the input port
  always_comb begin
    logic        is_sw;
    logic [2:0]  lim;
    logic [19:0] int_wide;
    logic [19:0] frac_wide;
    logic [4:0]  count;

    prefix_pos_nxt  = prefix_pos_r;
    prefix_fail_nxt = prefix_fail_r;
    field_idx_nxt   = field_idx_r;
    last_comma_nxt  = last_comma_r;
    field_len_nxt   = field_len_r;
    first_char_nxt  = first_char_r;
    int_acc_nxt     = int_acc_r;
    frac_acc_nxt    = frac_acc_r;
    frac_cnt_nxt    = frac_cnt_r;
    seen_point_nxt  = seen_point_r;
    stopped_nxt     = stopped_r;
    alt_neg_nxt     = alt_neg_r;
    neg_lat_nxt     = neg_lat_r;
    neg_lon_nxt     = neg_lon_r;

    // Field payload is taken before the field is cleared
    ev_nxt.tag.kind    = gsp_pkg::KIND_NONE;
    ev_nxt.tag.status  = gsp_pkg::ST_OK;
    ev_nxt.tag.alt_neg = alt_neg_r;
    ev_nxt.tag.neg_lat = neg_lat_r;
    ev_nxt.tag.neg_lon = neg_lon_r;
    ev_nxt.int_acc     = int_acc_r;
    ev_nxt.frac_acc    = frac_acc_r;
    ev_nxt.frac_cnt    = frac_cnt_r;

    is_sw = (field_len_r == 2'd1) &&
            ((first_char_r == gsp_pkg::CH_S) || (first_char_r == gsp_pkg::CH_W));
    lim   = (field_idx_r == gsp_pkg::FLD_ALT) ? gsp_pkg::ALT_FRAC_LIMIT
                                              : gsp_pkg::FRAC_LIMIT;
    int_wide  = 20'(int_acc_r) * 20'd10 + {16'd0, in_byte_req[3:0]};
    frac_wide = 20'(frac_acc_r) * 20'd10 + {16'd0, in_byte_req[3:0]};

    // Prefix compare
    if (prefix_pos_r < gsp_pkg::PREFIX_LEN) begin
      if (in_byte_req != gsp_pkg::gsp_prefix_char(prefix_pos_r)) begin
        prefix_fail_nxt = 1'b1;
      end
      prefix_pos_nxt = prefix_pos_r + 3'd1;
    end

    if (in_byte_req == gsp_pkg::CH_COMMA) begin
      // End of field
      case (field_idx_r)
        gsp_pkg::FLD_LAT:     ev_nxt.tag.kind = gsp_pkg::KIND_LAT;
        gsp_pkg::FLD_LON:     ev_nxt.tag.kind = gsp_pkg::KIND_LON;
        gsp_pkg::FLD_ALT:     ev_nxt.tag.kind = gsp_pkg::KIND_ALT;
        gsp_pkg::FLD_LAT_DIR: begin
          if (is_sw) neg_lat_nxt = 1'b1;
        end
        gsp_pkg::FLD_LON_DIR: begin
          if (is_sw) neg_lon_nxt = 1'b1;
        end
        default: ;
      endcase
      if (field_idx_r < gsp_pkg::FIELDS_NEEDED) begin
        field_idx_nxt = field_idx_r + 4'd1;
      end
      field_len_nxt  = 2'd0;
      first_char_nxt = 8'd0;
      int_acc_nxt    = 17'd0;
      frac_acc_nxt   = 17'd0;
      frac_cnt_nxt   = 3'd0;
      seen_point_nxt = 1'b0;
      stopped_nxt    = 1'b0;
      alt_neg_nxt    = 1'b0;
      last_comma_nxt = 1'b1;
    end else begin
      // Character inside a field
      last_comma_nxt = 1'b0;
      if (field_len_r == 2'd0) first_char_nxt = in_byte_req;
      if (field_len_r < 2'd2)  field_len_nxt  = field_len_r + 2'd1;
      if (!stopped_r) begin
        if ((field_idx_r == gsp_pkg::FLD_ALT) && (field_len_r == 2'd0) &&
            (in_byte_req inside {gsp_pkg::CH_MINUS, gsp_pkg::CH_PLUS})) begin
          alt_neg_nxt = (in_byte_req == gsp_pkg::CH_MINUS);
        end else if (in_byte_req inside {[gsp_pkg::CH_ZERO:gsp_pkg::CH_NINE]}) begin
          if (!seen_point_r) begin
            int_acc_nxt = (int_wide > 20'(gsp_pkg::INT_SAT)) ? gsp_pkg::INT_SAT
                                                              : int_wide[16:0];
          end else if (frac_cnt_r < lim) begin
            frac_acc_nxt = frac_wide[16:0];
            frac_cnt_nxt = frac_cnt_r + 3'd1;
          end
        end else if ((in_byte_req == gsp_pkg::CH_POINT) && !seen_point_r) begin
          seen_point_nxt = 1'b1;
        end else begin
          stopped_nxt = 1'b1;
        end
      end
    end

    // Sentence end: status, then start over
    count = {1'b0, field_idx_nxt} + {4'd0, ~last_comma_nxt};
    if (in_last) begin
      ev_nxt.tag.kind    = gsp_pkg::KIND_END;
      ev_nxt.tag.neg_lat = neg_lat_nxt;
      ev_nxt.tag.neg_lon = neg_lon_nxt;
      if ((prefix_pos_nxt < gsp_pkg::PREFIX_LEN) || prefix_fail_nxt) begin
        ev_nxt.tag.status = gsp_pkg::ST_NOT_GGA;
      end else if (count < {1'b0, gsp_pkg::FIELDS_NEEDED}) begin
        ev_nxt.tag.status = gsp_pkg::ST_SHORT;
      end else begin
        ev_nxt.tag.status = gsp_pkg::ST_OK;
      end
      prefix_pos_nxt  = 3'd0;
      prefix_fail_nxt = 1'b0;
      field_idx_nxt   = 4'd0;
      last_comma_nxt  = 1'b0;
      field_len_nxt   = 2'd0;
      first_char_nxt  = 8'd0;
      int_acc_nxt     = 17'd0;
      frac_acc_nxt    = 17'd0;
      frac_cnt_nxt    = 3'd0;
      seen_point_nxt  = 1'b0;
      stopped_nxt     = 1'b0;
      alt_neg_nxt     = 1'b0;
      neg_lat_nxt     = 1'b0;
      neg_lon_nxt     = 1'b0;
    end
  end

  // Parser state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_pos_r  <= 3'd0;
      prefix_fail_r <= 1'b0;
      field_idx_r   <= 4'd0;
      last_comma_r  <= 1'b0;
      field_len_r   <= 2'd0;
      first_char_r  <= 8'd0;
      int_acc_r     <= 17'd0;
      frac_acc_r    <= 17'd0;
      frac_cnt_r    <= 3'd0;
      seen_point_r  <= 1'b0;
      stopped_r     <= 1'b0;
      alt_neg_r     <= 1'b0;
      neg_lat_r     <= 1'b0;
      neg_lon_r     <= 1'b0;
    end else if (accept) begin
      prefix_pos_r  <= prefix_pos_nxt;
      prefix_fail_r <= prefix_fail_nxt;
      field_idx_r   <= field_idx_nxt;
      last_comma_r  <= last_comma_nxt;
      field_len_r   <= field_len_nxt;
      first_char_r  <= first_char_nxt;
      int_acc_r     <= int_acc_nxt;
      frac_acc_r    <= frac_acc_nxt;
      frac_cnt_r    <= frac_cnt_nxt;
      seen_point_r  <= seen_point_nxt;
      stopped_r     <= stopped_nxt;
      alt_neg_r     <= alt_neg_nxt;
      neg_lat_r     <= neg_lat_nxt;
      neg_lon_r     <= neg_lon_nxt;
    end
  end

  // Event register; a bubble when no byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r.tag <= '0;
    end else if (advance) begin
      ev_r.tag <= accept ? ev_nxt.tag : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r.int_acc  <= ev_nxt.int_acc;
      ev_r.frac_acc <= ev_nxt.frac_acc;
      ev_r.frac_cnt <= ev_nxt.frac_cnt;
    end
  end

endmodule

// ----- src/gsp_convert.sv -----
// Five-stage fixed-point converter: ddmm.mmmmm to 1e-7 degree, altitude to mm
module gsp_convert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  gsp_pkg::gsp_event_t  ev_i,
  output gsp_pkg::gsp_result_t res_o
);

  gsp_pkg::gsp_tag_t tag1_r, tag2_r, tag3_r, tag4_r;
  gsp_pkg::gsp_result_t res_r;

  // Stage payloads
  logic [16:0] x1_r, x2_r;
  logic [16:0] frac1_r;
  logic [2:0]  cnt1_r;
  logic [9:0]  q1_r, q2_r;
  logic [6:0]  rem3_r;
  logic [16:0] fs3_r;
  logic [23:0] me5_4_r;
  logic [33:0] deg4_r;
  logic [26:0] alt4_r;
  logic [24:0] third5_r;
  logic [33:0] deg5_r;
  logic [26:0] alt5_r;

  logic [34:0] prod100;
  logic [16:0] diff100;
  logic [2:0]  cnt_cap;
  logic [2:0]  scale_e;
  logic [33:0] frac_prod;
  logic [50:0] prod53;
  logic [34:0] coord_sum;
  logic signed [27:0] alt_s;

  assign res_o = res_r;

  // Stage 1: degrees = x / 100 by reciprocal multiply
  assign prod100 = 35'(ev_i.int_acc) * 35'(gsp_pkg::RECIP100);

  // Stage 2: minutes remainder, fraction scaled to full digit count
  assign diff100 = x1_r - 17'(q1_r) * 17'd100;
  always_comb begin
    if (tag1_r.kind == gsp_pkg::KIND_ALT) begin
      cnt_cap = (cnt1_r > gsp_pkg::ALT_FRAC_LIMIT) ? gsp_pkg::ALT_FRAC_LIMIT : cnt1_r;
      scale_e = gsp_pkg::ALT_FRAC_LIMIT - cnt_cap;
    end else begin
      cnt_cap = (cnt1_r > 3'd5) ? 3'd5 : cnt1_r;
      scale_e = 3'd5 - cnt_cap;
    end
  end
  assign frac_prod = 34'(frac1_r) * 34'(gsp_pkg::gsp_pow10(scale_e));

  // Stage 4: minutes_e5 * 5 / 3 by reciprocal multiply
  assign prod53 = 51'(me5_4_r) * 51'(gsp_pkg::FIVE_THIRDS);

  // Stage 5: sum and saturate, signed altitude
  assign coord_sum = 35'(deg5_r) + 35'(third5_r);
  assign alt_s     = tag4_r.alt_neg ? -$signed({1'b0, alt5_r}) : $signed({1'b0, alt5_r});

  // Token kinds and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r    <= '0;
      tag2_r    <= '0;
      tag3_r    <= '0;
      tag4_r    <= '0;
      res_r.tag <= '0;
    end else if (advance) begin
      tag1_r    <= ev_i.tag;
      tag2_r    <= tag1_r;
      tag3_r    <= tag2_r;
      tag4_r    <= tag3_r;
      res_r.tag <= tag4_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (advance) begin
      x1_r    <= ev_i.int_acc;
      frac1_r <= ev_i.frac_acc;
      cnt1_r  <= ev_i.frac_cnt;
      q1_r    <= prod100[33:gsp_pkg::RECIP100_SH];

      x2_r    <= x1_r;
      q2_r    <= q1_r;
      rem3_r  <= diff100[6:0];
      fs3_r   <= frac_prod[16:0];

      // degrees, minutes and altitude of the same token meet here
      me5_4_r <= 24'(rem3_r) * 24'd100000 + 24'(fs3_r);
      deg4_r  <= 34'(q2_r) * 34'd10000000;
      alt4_r  <= 27'(x2_r) * 27'd1000 + 27'(fs3_r);

      third5_r <= prod53[50:gsp_pkg::FIVE_THIRDS_SH];
      deg5_r   <= deg4_r;
      alt5_r   <= alt4_r;

      res_r.coord_mag <= (coord_sum > 35'(gsp_pkg::COORD_MAX)) ? gsp_pkg::COORD_MAX
                                                                : coord_sum[33:0];
      res_r.alt       <= alt_s;
    end
  end

endmodule

// ----- src/gga_sentence_position_parser_top.sv -----
// Top level of the GGA position parser: parser, converter, result commit
//
// Input channel: one sentence byte per transaction (in_byte_req), in_last on
// the final byte. Output channel: one result transaction per sentence with
// out_status (0 ok, 1 not a GGA sentence, 2 fewer than 15 fields) and the
// held latitude/longitude (1e-7 degree) and altitude (mm). The held values
// change only on a sentence with status ok; otherwise the previous ones repeat.
// Throughput: one byte per cycle while in_stall is low. After the last byte
// is accepted, the result passes the parser event register, the five-stage
// conversion pipeline (two reciprocal multiplies, one scaling multiply) and
// the output register. The output register parts both sides: while a result
// waits under out_stall bytes keep flowing; in_stall rises only when a second
// sentence end reaches the last pipeline stage before the waiting result is taken.
// Reset (rst_n low, synchronous) clears the parse state, the pipeline tags, the
// output valid and the held values to zero. No clearing pass is needed.
`include "gga_sentence_position_parser_top_defines.svh"

module gga_sentence_position_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte_req,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [34:0] out_latitude,
  output logic signed [34:0] out_longitude,
  output logic signed [27:0] out_altitude_mm
);

  gsp_pkg::gsp_event_t  ev;
  gsp_pkg::gsp_result_t res;

  logic advance;
  logic fin;

  logic [33:0]        work_lat_r;
  logic [33:0]        work_lon_r;
  logic signed [27:0] work_alt_r;
  logic signed [34:0] held_lat_r, held_lat_nxt;
  logic signed [34:0] held_lon_r, held_lon_nxt;
  logic signed [27:0] held_alt_r, held_alt_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [34:0] out_lat_r;
  logic signed [34:0] out_lon_r;
  logic signed [27:0] out_alt_r;

  gsp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte_req (in_byte_req),
    .in_last     (in_last),
    .advance     (advance),
    .ev_o        (ev)
  );

  gsp_convert u_convert (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .ev_i    (ev),
    .res_o   (res)
  );

  // Pipeline moves unless a sentence end meets a full, stalled output
  assign advance = !((res.tag.kind == gsp_pkg::KIND_END) && out_valid_r && out_stall);
  assign fin     = advance && (res.tag.kind == gsp_pkg::KIND_END);

  // Held values for a finished sentence
  always_comb begin
    held_lat_nxt = held_lat_r;
    held_lon_nxt = held_lon_r;
    held_alt_nxt = held_alt_r;
    if (res.tag.status == gsp_pkg::ST_OK) begin
      held_lat_nxt = res.tag.neg_lat ? -$signed({1'b0, work_lat_r})
                                     : $signed({1'b0, work_lat_r});
      held_lon_nxt = res.tag.neg_lon ? -$signed({1'b0, work_lon_r})
                                     : $signed({1'b0, work_lon_r});
      held_alt_nxt = work_alt_r;
    end
  end

  // Working and held values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_lat_r <= '0;
      work_lon_r <= '0;
      work_alt_r <= '0;
      held_lat_r <= '0;
      held_lon_r <= '0;
      held_alt_r <= '0;
    end else if (advance) begin
      case (res.tag.kind)
        gsp_pkg::KIND_LAT: work_lat_r <= res.coord_mag;
        gsp_pkg::KIND_LON: work_lon_r <= res.coord_mag;
        gsp_pkg::KIND_ALT: work_alt_r <= res.alt;
        gsp_pkg::KIND_END: begin
          held_lat_r <= held_lat_nxt;
          held_lon_r <= held_lon_nxt;
          held_alt_r <= held_alt_nxt;
          work_lat_r <= '0;
          work_lon_r <= '0;
          work_alt_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= res.tag.status;
      out_lat_r    <= held_lat_nxt;
      out_lon_r    <= held_lon_nxt;
      out_alt_r    <= held_alt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_latitude    = out_lat_r;
  assign out_longitude   = out_lon_r;
  assign out_altitude_mm = out_alt_r;

  // Checks
  `GSP_ASSERT_IMPL(a_stall_needs_blocked_output, in_stall, out_valid && out_stall, "input stalled while output is free")
  `GSP_ASSERT_NEXT(a_held_kept_on_failure, fin && (res.tag.status != gsp_pkg::ST_OK), $stable(held_lat_r) && $stable(held_lon_r) && $stable(held_alt_r), "held values changed on a failed sentence")
  `GSP_ASSERT_NEXT(a_work_cleared_at_end, fin, (work_lat_r == '0) && (work_lon_r == '0) && (work_alt_r == '0), "working values not cleared after sentence end")

endmodule

// ----- tb/gga_sentence_position_parser_checker.sv -----
// Checker for the GGA position parser: fix prediction and result comparison
module gga_sentence_position_parser_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_byte_req,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [34:0] out_latitude,
  input  logic signed [34:0] out_longitude,
  input  logic signed [27:0] out_altitude_mm,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // "$GPGGA", first character in the top byte
  localparam logic [47:0] GGA_HDR   = 48'h244750474741;
  localparam longint      COORD_SAT = longint'(gsp_pkg::COORD_MAX);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [34:0] lat;
    logic signed [34:0] lon;
    logic signed [27:0] alt;
  } fix_report_t;

  fix_report_t report_q[$];

  // Parser state of the sentence in flight
  int unsigned hdr_pos;
  bit          hdr_bad;
  int unsigned field_no;
  bit          after_comma;
  int unsigned chars_in_field;
  logic [7:0]  lead_char;
  int unsigned whole_part;
  int unsigned frac_part;
  int unsigned frac_digits;
  bit          got_point;
  bit          num_done;
  bit          alt_minus;
  longint      lat_acc, lon_acc, alt_acc;
  // Values of the last accepted sentence
  longint      lat_held, lon_held, alt_held;

  initial fail_count = 0;
  initial pending = 0;

  function automatic longint ten_to(int unsigned e);
    longint p;
    p = 1;
    repeat (e) p = p * 10;
    return p;
  endfunction

  function void reset_field();
    chars_in_field = 0;
    lead_char      = 8'h00;
    whole_part     = 0;
    frac_part      = 0;
    frac_digits    = 0;
    got_point      = 1'b0;
    num_done       = 1'b0;
    alt_minus      = 1'b0;
  endfunction

  function void reset_sentence();
    hdr_pos     = 0;
    hdr_bad     = 1'b0;
    field_no    = 0;
    after_comma = 1'b0;
    reset_field();
    lat_acc = 0;
    lon_acc = 0;
    alt_acc = 0;
  endfunction

  // ddmm.mmmmm -> 1e-7 degree, truncated, saturated
  function automatic longint coord_fixed();
    int unsigned n;
    longint      degs, min_e5, v;
    n      = (frac_digits > 5) ? 5 : frac_digits;
    degs   = longint'(whole_part / 100);
    min_e5 = longint'(whole_part % 100) * 100000 + longint'(frac_part) * ten_to(5 - n);
    v      = degs * 10000000 + (min_e5 * 5) / 3;
    return (v > COORD_SAT) ? COORD_SAT : v;
  endfunction

  function automatic longint alt_fixed();
    int unsigned n;
    longint      v;
    n = (frac_digits > 3) ? 3 : frac_digits;
    v = longint'(whole_part) * 1000 + longint'(frac_part) * ten_to(3 - n);
    return alt_minus ? -v : v;
  endfunction

  // Direction flips only on a field that is exactly S or W
  function automatic bit hemisphere_flip();
    return chars_in_field == 1 &&
           (lead_char == gsp_pkg::CH_S || lead_char == gsp_pkg::CH_W);
  endfunction

  function void close_field();
    case (field_no)
      gsp_pkg::FLD_LAT:     lat_acc = coord_fixed();
      gsp_pkg::FLD_LAT_DIR: if (hemisphere_flip()) lat_acc = -lat_acc;
      gsp_pkg::FLD_LON:     lon_acc = coord_fixed();
      gsp_pkg::FLD_LON_DIR: if (hemisphere_flip()) lon_acc = -lon_acc;
      gsp_pkg::FLD_ALT:     alt_acc = alt_fixed();
      default: ;
    endcase
  endfunction

  function void absorb_char(logic [7:0] c);
    int unsigned prev_len, lim, d, n;
    prev_len = chars_in_field;
    if (chars_in_field == 0) lead_char = c;
    if (chars_in_field < 2) chars_in_field++;
    if (num_done) return;
    // a sign only counts as the first character of the altitude
    if (field_no == gsp_pkg::FLD_ALT && prev_len == 0 &&
        (c == gsp_pkg::CH_MINUS || c == gsp_pkg::CH_PLUS)) begin
      alt_minus = (c == gsp_pkg::CH_MINUS);
      return;
    end
    lim = (field_no == gsp_pkg::FLD_ALT) ? gsp_pkg::ALT_FRAC_LIMIT : gsp_pkg::FRAC_DIGITS;
    if (c >= gsp_pkg::CH_ZERO && c <= gsp_pkg::CH_NINE) begin
      d = int'(c) - int'(gsp_pkg::CH_ZERO);
      if (!got_point) begin
        n = whole_part * 10 + d;
        whole_part = (n > gsp_pkg::INT_SAT) ? gsp_pkg::INT_SAT : n;
      end else if (frac_digits < lim) begin
        frac_part = frac_part * 10 + d;
        frac_digits++;
      end
    end else if (c == gsp_pkg::CH_POINT && !got_point) begin
      got_point = 1'b1;
    end else begin
      num_done = 1'b1;
    end
  endfunction

  // Advance the parser by one byte; the final byte yields a fix report
  function void predict_byte(logic [7:0] c, logic is_end);
    fix_report_t r;
    int unsigned fields;
    if (hdr_pos < 6) begin
      if (c != GGA_HDR[8 * (5 - hdr_pos) +: 8]) hdr_bad = 1'b1;
      hdr_pos++;
    end
    if (c == gsp_pkg::CH_COMMA) begin
      close_field();
      if (field_no < gsp_pkg::FIELDS_NEEDED) field_no++;
      reset_field();
      after_comma = 1'b1;
    end else begin
      absorb_char(c);
      after_comma = 1'b0;
    end
    if (is_end) begin
      fields = field_no + (after_comma ? 0 : 1);
      if (hdr_pos < 6 || hdr_bad) begin
        r.status = gsp_pkg::ST_NOT_GGA;
      end else if (fields < gsp_pkg::FIELDS_NEEDED) begin
        r.status = gsp_pkg::ST_SHORT;
      end else begin
        r.status = gsp_pkg::ST_OK;
        lat_held = lat_acc;
        lon_held = lon_acc;
        alt_held = alt_acc;
      end
      r.lat = lat_held[34:0];
      r.lon = lon_held[34:0];
      r.alt = alt_held[27:0];
      report_q.insert(report_q.size(), r);
      reset_sentence();
    end
  endfunction

  function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result transaction is compared before this edge's byte is folded in
  always @(posedge clk) begin
    fix_report_t want;
    if (!rst_n) begin
      reset_sentence();
      lat_held = 0;
      lon_held = 0;
      alt_held = 0;
      report_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result transaction with no sentence end pending");
          fail_count++;
        end else begin
          want = report_q[0];
          report_q.delete(0);
          check_field("status", $signed({1'b0, want.status}), $signed({1'b0, out_status}));
          check_field("latitude", want.lat, out_latitude);
          check_field("longitude", want.lon, out_longitude);
          check_field("altitude_mm", want.alt, out_altitude_mm);
        end
      end
      if (in_valid && !in_stall) predict_byte(in_byte_req, in_last);
    end
    pending = report_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top of the GGA position parser: sentence stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEM_COUNT   = 1150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte_req = 8'h00;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [34:0] out_latitude;
  logic signed [34:0] out_longitude;
  logic signed [27:0] out_altitude_mm;
  int                 fail_count;
  int                 pending;

  int          tx_gap_pct = 25;
  int          rx_hold_pct = 85;
  int          bytes_sent = 0;
  int unsigned cycles = 0;
  logic [7:0]  sentence_q[$];

  gga_sentence_position_parser_top u_top (.*);
  gga_sentence_position_parser_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_hold_pct);
  end

  // Append one byte to the sentence buffer
  function void add_byte(logic [7:0] b);
    sentence_q.insert(sentence_q.size(), b);
  endfunction

  // One byte transaction; random gaps before it, held until accepted
  task automatic put_byte(input logic [7:0] b, input logic is_end);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= b;
    in_last     <= is_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the buffered sentence; idle mix follows the byte count
  task automatic send_sentence();
    for (int i = 0; i < sentence_q.size(); i++) begin
      if (bytes_sent < 500) begin
        tx_gap_pct  = 25;
        rx_hold_pct = 85;
      end else if (bytes_sent < 1000) begin
        tx_gap_pct  = 85;
        rx_hold_pct = 25;
      end else begin
        tx_gap_pct  = 0;
        rx_hold_pct = 0;
      end
      put_byte(sentence_q[i], i == sentence_q.size() - 1);
      bytes_sent++;
    end
    sentence_q.delete();
  endtask

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  task automatic send_text(string s);
    put_str(s);
    send_sentence();
  endtask

  // Fifteen-field sentence with the given position fields
  function automatic string gga_text(string lat, string ns, string lon, string ew,
                                     string alt);
    return {"$GPGGA,092750,", lat, ",", ns, ",", lon, ",", ew, ",1,08,0.9,", alt,
            ",M,46.9,M,,0000"};
  endfunction

  // Random field content
  function void add_digits(int n, bit nines);
    repeat (n) add_byte(gsp_pkg::CH_ZERO + (nines ? 8'd9 : 8'($urandom_range(9))));
  endfunction

  function void add_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == gsp_pkg::CH_COMMA);
    add_byte(c);
  endfunction

  function void add_coord();
    bit nines;
    if ($urandom_range(9) == 0) return;
    nines = ($urandom_range(9) == 0);
    add_digits(($urandom_range(9) < 7) ? $urandom_range(3, 5) : $urandom_range(0, 8), nines);
    if ($urandom_range(9) < 8) begin
      add_byte(gsp_pkg::CH_POINT);
      add_digits($urandom_range(0, 7), nines);
    end
    if ($urandom_range(9) == 0) begin
      add_junk();
      add_digits($urandom_range(0, 2), 1'b0);
    end
  endfunction

  function void add_dir();
    case ($urandom_range(7))
      0: put_str("N");
      1: put_str("S");
      2: put_str("E");
      3: put_str("W");
      4: ;
      5: put_str("SW");
      6: put_str("s");
      default: add_junk();
    endcase
  endfunction

  function void add_alt();
    if ($urandom_range(9) < 3) add_byte($urandom_range(1) ? gsp_pkg::CH_MINUS : gsp_pkg::CH_PLUS);
    add_digits($urandom_range(0, 9), $urandom_range(9) == 0);
    if ($urandom_range(9) < 7) begin
      add_byte(gsp_pkg::CH_POINT);
      add_digits($urandom_range(0, 5), 1'b0);
    end
    if ($urandom_range(9) == 0) begin
      add_junk();
      add_digits($urandom_range(0, 2), 1'b0);
    end
  endfunction

  function void add_misc();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(3) == 0) add_junk();
      else add_digits(1, 1'b0);
    end
  endfunction

  function void build_gga(int nfields, bit trailing);
    put_str("$GPGGA");
    for (int f = 1; f < nfields; f++) begin
      add_byte(gsp_pkg::CH_COMMA);
      case (f)
        gsp_pkg::FLD_LAT, gsp_pkg::FLD_LON:         add_coord();
        gsp_pkg::FLD_LAT_DIR, gsp_pkg::FLD_LON_DIR: add_dir();
        gsp_pkg::FLD_ALT:                           add_alt();
        default:                                    add_misc();
      endcase
    end
    if (trailing) add_byte(gsp_pkg::CH_COMMA);
  endfunction

  // Mostly well-formed sentences, the rest broken or noise
  function void build_random();
    int         r, k;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 65) begin
      build_gga(($urandom_range(9) == 0) ? $urandom_range(16, 18) : 15, $urandom_range(4) == 0);
    end else if (r < 73) begin
      build_gga(15, 1'b0);
      k = $urandom_range(5);
      do b = 8'($urandom_range(255)); while (b == sentence_q[k]);
      sentence_q[k] = b;
    end else if (r < 82) begin
      build_gga($urandom_range(1, 14), $urandom_range(1));
    end else if (r < 88) begin
      put_str("$GPGGA");
      k = $urandom_range(1, 5);
      while (sentence_q.size() > k) void'(sentence_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sentences
    send_text(gga_text("4807.038", "N", "01131.000", "E", "545.4"));
    send_text(gga_text("9959.99999", "S", "17959.99999", "W", "-99999.999"));
    send_text(gga_text("", "N", "", "E", ""));
    send_text(gga_text("4807", "S", "01131", "W", "+12"));
    send_text(gga_text("1234567.1234567", "SS", "99999999.9", "w", "999999999.99999"));
    send_text(gga_text("48x07.5", "W", "12.3.4", "S", "1-2.3"));
    send_text(gga_text(".5", "S", "0.", "W", "-.5"));
    send_text(gga_text("-4807.0", "S", "+01131.0", "W", "--5"));
    // failures must repeat the held fix
    send_text("$GPGGA,1,2,3");
    put_str("$GPGGA");
    repeat (14) add_byte(gsp_pkg::CH_COMMA);
    send_sentence();
    send_text("$GPGG");
    send_text("$GNGGA,1,2,3,4,5,6,7,8,9,10,11,12,13,14");
    send_text(",");
    sentence_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_sentence();
    // fifteen fields, all empty but the last, then a trailing comma on a full sentence
    put_str("$GPGGA");
    repeat (14) add_byte(gsp_pkg::CH_COMMA);
    put_str("x");
    send_sentence();
    send_text({gga_text("0000.00001", "S", "18000.0", "W", "0.001"), ","});
    send_text({gga_text("3000.5", "N", "00030.25", "W", "7"), ",extra,,9"});

    // Random sentences up to the byte budget
    while (bytes_sent < ITEM_COUNT) begin
      build_random();
      send_sentence();
    end
    in_valid <= 1'b0;

    // Drain
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/gsp_pkg.sv
src/gsp_parser.sv
src/gsp_convert.sv
src/gga_sentence_position_parser_top.sv
tb/gga_sentence_position_parser_checker.sv
tb/tb_top.sv
